### sv/bloom_filter_key_range_check_macros.svh
// assertion macros shared by the bloom filter key range check block
`ifndef BLOOM_FILTER_KEY_RANGE_CHECK_MACROS_SVH
`define BLOOM_FILTER_KEY_RANGE_CHECK_MACROS_SVH

// same-cycle implication
`define BFKR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFKR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/bfkr_pkg.sv
`default_nettype none

package bfkr_pkg;

   localparam int unsigned KEY_W       = 64;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned ROW_W       = 32;
   localparam int unsigned ROW_BIT_W   = 5;
   localparam int unsigned RSP_TDATA_W = 8;
   localparam int unsigned CSR_AW      = 3;
   localparam int unsigned CSR_DW      = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_INSERT_DONE = 2'd0;
   localparam status_type STATUS_MAYBE       = 2'd1;
   localparam status_type STATUS_OUT_RANGE   = 2'd2;
   localparam status_type STATUS_MISS        = 2'd3;

   localparam logic        CSR_IDX_HASH_SEED = 1'b0;
   localparam logic [31:0] HASH_SEED_RESET   = 32'd1;

   localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
   localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
   localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] MM_LEN  = 64'd8;

   typedef struct packed {
      logic        done;
      logic [63:0] h1;
      logic [63:0] h2;
   } hash_rsp_type;

endpackage

`default_nettype wire

### sv/bfkr_ram.sv
`default_nettype none

module bfkr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 2560,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic [AW-1:0]    addr,
   input  wire logic             we,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/bfkr_hash.sv
`default_nettype none

module bfkr_hash
   import bfkr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [63:0]  key,
   input  wire logic [31:0]  seed,
   output hash_rsp_type      rsp
);

   localparam logic [3:0] HS_IDLE = 4'd0;
   localparam logic [3:0] HS_K1   = 4'd1;
   localparam logic [3:0] HS_K2   = 4'd2;
   localparam logic [3:0] HS_AB1  = 4'd3;
   localparam logic [3:0] HS_AB2  = 4'd4;
   localparam logic [3:0] HS_FA1  = 4'd5;
   localparam logic [3:0] HS_FA2  = 4'd6;
   localparam logic [3:0] HS_FB1  = 4'd7;
   localparam logic [3:0] HS_FB2  = 4'd8;
   localparam logic [3:0] HS_AB3  = 4'd9;
   localparam logic [3:0] HS_AB4  = 4'd10;

   function automatic logic [63:0] shift_mix(input logic [63:0] x);
      return x ^ (x >> 33);
   endfunction

   logic [3:0]  state_ff, state_in;
   logic [1:0]  mp_ff, mp_in;
   logic [63:0] w_ff, w_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] pp_ff, pp_in;
   logic [63:0] acc_ff, acc_in;
   logic        done_ff, done_in;

   logic [63:0] mul_const;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod;
   logic        is_mul;
   logic [63:0] seed_ext;

   always_comb begin
      unique case (state_ff)
         HS_K1:           mul_const = MM_C1;
         HS_K2:           mul_const = MM_C2;
         HS_FA1, HS_FB1:  mul_const = FMIX_M1;
         HS_FA2, HS_FB2:  mul_const = FMIX_M2;
         default:         mul_const = '0;
      endcase
   end

   assign is_mul = (state_ff == HS_K1) || (state_ff == HS_K2) ||
                   (state_ff == HS_FA1) || (state_ff == HS_FA2) ||
                   (state_ff == HS_FB1) || (state_ff == HS_FB2);

   // 64x64 product mod 2^64 from three 32x32 partial products
   assign mul_a = (mp_ff == 2'd2) ? w_ff[63:32] : w_ff[31:0];
   assign mul_b = (mp_ff == 2'd1) ? mul_const[63:32] : mul_const[31:0];
   assign pp_in = {32'b0, mul_a} * {32'b0, mul_b};
   assign prod  = {acc_ff[63:32] + pp_ff[31:0], acc_ff[31:0]};
   assign seed_ext = {32'b0, seed};

   always_comb begin
      state_in = state_ff;
      mp_in    = mp_ff;
      w_in     = w_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      if (is_mul) begin
         mp_in = mp_ff + 2'd1;
         unique case (mp_ff)
            2'd1:    acc_in = pp_ff;
            2'd2:    acc_in = {acc_ff[63:32] + pp_ff[31:0], acc_ff[31:0]};
            default: acc_in = acc_ff;
         endcase
      end
      unique case (state_ff)
         HS_IDLE: begin
            if (start) begin
               w_in     = key;
               mp_in    = 2'd0;
               state_in = HS_K1;
            end
         end
         HS_K1: begin
            if (mp_ff == 2'd3) begin
               w_in     = {prod[32:0], prod[63:33]};
               state_in = HS_K2;
            end
         end
         HS_K2: begin
            if (mp_ff == 2'd3) begin
               a_in     = seed_ext ^ prod ^ MM_LEN;
               b_in     = seed_ext ^ MM_LEN;
               state_in = HS_AB1;
            end
         end
         HS_AB1: begin
            a_in     = a_ff + b_ff;
            state_in = HS_AB2;
         end
         HS_AB2: begin
            b_in     = b_ff + a_ff;
            w_in     = shift_mix(a_ff);
            state_in = HS_FA1;
         end
         HS_FA1: begin
            if (mp_ff == 2'd3) begin
               w_in     = shift_mix(prod);
               state_in = HS_FA2;
            end
         end
         HS_FA2: begin
            if (mp_ff == 2'd3) begin
               a_in     = shift_mix(prod);
               w_in     = shift_mix(b_ff);
               state_in = HS_FB1;
            end
         end
         HS_FB1: begin
            if (mp_ff == 2'd3) begin
               w_in     = shift_mix(prod);
               state_in = HS_FB2;
            end
         end
         HS_FB2: begin
            if (mp_ff == 2'd3) begin
               b_in     = shift_mix(prod);
               state_in = HS_AB3;
            end
         end
         HS_AB3: begin
            a_in     = a_ff + b_ff;
            state_in = HS_AB4;
         end
         HS_AB4: begin
            b_in     = b_ff + a_ff;
            done_in  = 1'b1;
            state_in = HS_IDLE;
         end
         default: begin
            state_in = HS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         mp_ff    <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mp_ff    <= mp_in;
         done_ff  <= done_in;
      end
      w_ff   <= w_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.h1   = a_ff;
   assign rsp.h2   = b_ff;

endmodule

`default_nettype wire

### sv/bfkr_mod.sv
`default_nettype none

module bfkr_mod
   import bfkr_pkg::*;
#(
   parameter int unsigned MODULUS = 81920,
   localparam int unsigned PW = $clog2(MODULUS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W-1:0] word,
   output logic                   done,
   output logic      [PW-1:0]     pos
);

   // floor(2^32 / MODULUS), the quotient estimate is low by at most one
   localparam logic [63:0]       RECIP_FULL = (64'd1 << WORD_W) / 64'(MODULUS);
   localparam logic [WORD_W-1:0] RECIP      = RECIP_FULL[WORD_W-1:0];
   localparam logic [WORD_W-1:0] MOD_W      = WORD_W'(MODULUS);

   logic [WORD_W-1:0]   word_ff, word_in;
   logic [2*WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0]   qmul_ff, qmul_in;
   logic [WORD_W-1:0]   diff_ff, diff_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [3:0]          vld_ff, vld_in;
   logic                done_ff, done_in;

   // reciprocal multiplication, then one compare and subtract
   assign word_in = start ? word : word_ff;
   assign prod_in = {{WORD_W{1'b0}}, word_ff} * {{WORD_W{1'b0}}, RECIP};
   assign qmul_in = prod_ff[2*WORD_W-1:WORD_W] * MOD_W;
   assign diff_in = word_ff - qmul_ff;
   assign vld_in  = {vld_ff[2:0], start};
   assign done_in = vld_ff[3];

   always_comb begin
      pos_in = pos_ff;
      if (vld_ff[3]) begin
         if (diff_ff >= MOD_W) begin
            pos_in = PW'(diff_ff - MOD_W);
         end else begin
            pos_in = PW'(diff_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         done_ff <= done_in;
      end
      word_ff <= word_in;
      prod_ff <= prod_in;
      qmul_ff <= qmul_in;
      diff_ff <= diff_in;
      pos_ff  <= pos_in;
   end

   assign done = done_ff;
   assign pos  = pos_ff;

endmodule

`default_nettype wire

### sv/bloom_filter_key_range_check.sv
// Bloom filter with key-range check for the keys of one sorted table. A request with
// tuser 0 inserts its 64-bit key: the key is hashed with MurmurHash3 x64_128 under the
// hash_seed register, the four 32-bit hash words are each reduced modulo FILTER_BITS and
// set one filter bit, and the stored lowest and highest key are widened. A request with
// tuser 1 queries its key and answers 2 when nothing was inserted or the key lies outside
// the stored range, 3 when one of its four bits is clear and 1 otherwise; an insert
// answers 0. Every request gives exactly one response. The filter bits live in a
// single-port RAM of 32-bit rows. An insert or an in-range query first waits for the
// hash, built on one shared 32x32 multiplier, then takes each filter bit in turn through
// the modulo reduction by reciprocal multiplication, a read and, for an insert, a
// write-back on the RAM port, and then loads the response and returns to idle. An
// out-of-range query skips the hash and goes straight to loading its response. A new
// request is taken only once the last one has loaded its response. A response that is
// not taken holds the next finished request, which stalls the input. After reset a
// clearing pass writes every RAM row, ceil(FILTER_BITS/32) of them (2560 by default),
// before the first request is taken.
`default_nettype none

`include "bloom_filter_key_range_check_macros.svh"

module bloom_filter_key_range_check
   import bfkr_pkg::*;
#(
   parameter int unsigned FILTER_BITS = 81920
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [KEY_W-1:0]       req_tdata,    // key
   input  wire logic [0:0]             req_tuser,    // opcode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,    // status, zero padded
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_AW-1:0]      csr_paddr,
   input  wire logic [CSR_DW-1:0]      csr_pwdata,
   output logic      [CSR_DW-1:0]      csr_prdata,
   output logic                        csr_pready
);

   localparam int unsigned PW   = $clog2(FILTER_BITS);
   localparam int unsigned ROWS = (FILTER_BITS + ROW_W - 1) / ROW_W;
   localparam int unsigned RW   = $clog2(ROWS);

   localparam logic [2:0] CS_CLEAR  = 3'd0;
   localparam logic [2:0] CS_IDLE   = 3'd1;
   localparam logic [2:0] CS_HASH   = 3'd2;
   localparam logic [2:0] CS_MOD    = 3'd3;
   localparam logic [2:0] CS_READ   = 3'd4;
   localparam logic [2:0] CS_UPDATE = 3'd5;
   localparam logic [2:0] CS_RESP   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [RW-1:0]    clr_row_ff, clr_row_in;
   logic             op_ff, op_in;
   logic [1:0]       word_idx_ff, word_idx_in;
   status_type       status_ff, status_in;
   logic [KEY_W-1:0] lowest_ff, lowest_in;
   logic [KEY_W-1:0] highest_ff, highest_in;
   logic             holds_ff, holds_in;
   logic [31:0]      seed_ff, seed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             req_accept;
   logic             csr_write;
   logic             hash_start;
   hash_rsp_type     hash_rsp;
   logic             mod_start;
   logic [WORD_W-1:0] mod_word;
   logic             mod_done;
   logic [PW-1:0]    mod_pos;
   logic [RW-1:0]    ram_addr;
   logic             ram_we;
   logic [ROW_W-1:0] ram_wdata;
   logic [ROW_W-1:0] ram_rdata;
   logic             filter_bit;
   logic             in_range;

   bfkr_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_tdata),
      .seed  (seed_ff),
      .rsp   (hash_rsp)
   );

   bfkr_mod #(
      .MODULUS (FILTER_BITS)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .word  (mod_word),
      .done  (mod_done),
      .pos   (mod_pos)
   );

   bfkr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_AW-1:2] == CSR_IDX_HASH_SEED);
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == CSR_IDX_HASH_SEED) ? seed_ff : '0;
   assign seed_in    = csr_write ? csr_pwdata : seed_ff;

   assign req_tready = (state_ff == CS_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign in_range   = holds_ff && (req_tdata >= lowest_ff) && (req_tdata <= highest_ff);
   assign filter_bit = ram_rdata[mod_pos[ROW_BIT_W-1:0]];

   always_comb begin
      unique case (word_idx_in)
         2'd0:    mod_word = hash_rsp.h1[31:0];
         2'd1:    mod_word = hash_rsp.h1[63:32];
         2'd2:    mod_word = hash_rsp.h2[31:0];
         default: mod_word = hash_rsp.h2[63:32];
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_row_in    = clr_row_ff;
      op_in         = op_ff;
      word_idx_in   = word_idx_ff;
      status_in     = status_ff;
      lowest_in     = lowest_ff;
      highest_in    = highest_ff;
      holds_in      = holds_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      hash_start    = 1'b0;
      mod_start     = 1'b0;
      ram_addr      = RW'(mod_pos >> ROW_BIT_W);
      ram_we        = 1'b0;
      ram_wdata     = ram_rdata | (ROW_W'(1) << mod_pos[ROW_BIT_W-1:0]);
      unique case (state_ff)
         CS_CLEAR: begin
            ram_addr   = clr_row_ff;
            ram_we     = 1'b1;
            ram_wdata  = '0;
            clr_row_in = clr_row_ff + RW'(1);
            if (clr_row_ff == RW'(ROWS - 1)) begin
               state_in = CS_IDLE;
            end
         end
         CS_IDLE: begin
            if (req_accept) begin
               op_in       = req_tuser[0];
               word_idx_in = 2'd0;
               if (req_tuser[0] == OP_INSERT) begin
                  if (req_tdata < lowest_ff) begin
                     lowest_in = req_tdata;
                  end
                  if (req_tdata > highest_ff) begin
                     highest_in = req_tdata;
                  end
                  holds_in  = 1'b1;
                  status_in = STATUS_INSERT_DONE;
                  state_in  = CS_HASH;
               end else if (!in_range) begin
                  status_in = STATUS_OUT_RANGE;
                  state_in  = CS_RESP;
               end else begin
                  status_in = STATUS_MAYBE;
                  state_in  = CS_HASH;
               end
            end
            hash_start = (state_in == CS_HASH);
         end
         CS_HASH: begin
            if (hash_rsp.done) begin
               mod_start = 1'b1;
               state_in  = CS_MOD;
            end
         end
         CS_MOD: begin
            if (mod_done) begin
               state_in = CS_READ;
            end
         end
         CS_READ: begin
            state_in = CS_UPDATE;
         end
         CS_UPDATE: begin
            if (op_ff == OP_INSERT) begin
               ram_we = 1'b1;
            end else if (!filter_bit) begin
               status_in = STATUS_MISS;
            end
            if (word_idx_ff == 2'd3) begin
               state_in = CS_RESP;
            end else begin
               word_idx_in = word_idx_ff + 2'd1;
               mod_start   = 1'b1;
               state_in    = CS_MOD;
            end
         end
         CS_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_CLEAR;
         clr_row_ff   <= '0;
         word_idx_ff  <= 2'd0;
         lowest_ff    <= '1;
         highest_ff   <= '0;
         holds_ff     <= 1'b0;
         seed_ff      <= HASH_SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         word_idx_ff  <= word_idx_in;
         lowest_ff    <= lowest_in;
         highest_ff   <= highest_in;
         holds_ff     <= holds_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2){1'b0}}, rsp_status_ff};

   `BFKR_ASSERT_NOW(a_hash_done_in_hash, clock, reset, hash_rsp.done, state_ff == CS_HASH, "hash finished outside hash wait")
   `BFKR_ASSERT_NOW(a_clear_blocks_req, clock, reset, state_ff == CS_CLEAR, ram_we && !req_tready, "clearing pass must write and hold off requests")
   `BFKR_ASSERT_NEXT(a_resp_load, clock, reset, state_ff == CS_RESP && (!rsp_valid_ff || rsp_tready), rsp_tvalid && rsp_tdata[1:0] == $past(status_ff), "response not loaded with request status")

endmodule

`default_nettype wire

### verif/bloom_filter_key_range_check_tb.sv
module bloom_filter_key_range_check_tb;
   import bfkr_pkg::*;

   localparam int unsigned FILTER_BITS  = 81920;
   localparam int unsigned STALL_LIMIT  = 8000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned RANDOM_ITEMS = 650;
   localparam logic [CSR_AW-1:0] ADDR_HASH_SEED = 3'd0;
   localparam logic [CSR_AW-1:0] ADDR_UNMAPPED  = 3'd4;
   localparam logic [KEY_W-1:0]  KEY_MID        = 64'h8000_0000_0000_0000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [KEY_W-1:0]       req_tdata   = '0;   // key
   logic [0:0]             req_tuser   = '0;   // opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // status, zero padded
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr   = '0;
   logic [CSR_DW-1:0]      csr_pwdata  = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   // shadow of the filter state
   bit               filter_set [FILTER_BITS];
   logic [KEY_W-1:0] lowest_key_q  = '1;
   logic [KEY_W-1:0] highest_key_q = '0;
   bit               holds_keys_q  = 1'b0;
   logic [31:0]      seed_q        = HASH_SEED_RESET;

   status_type       expected_status [$];
   logic [KEY_W-1:0] inserted_keys [$];
   int unsigned      status_count [4];
   int unsigned      error_count    = 0;
   int unsigned      seeds_used     = 0;
   bit               idle_enable    = 1'b1;
   bit               hold_pending   = 1'b0;
   int unsigned      hold_left      = 0;
   int unsigned      stall_left     = 0;

   bloom_filter_key_range_check #(
      .FILTER_BITS(FILTER_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic logic [63:0] mix_down(input logic [63:0] v);
      logic [63:0] m;
      m = v ^ (v >> 33);
      m = m * FMIX_M1;
      m = m ^ (m >> 33);
      m = m * FMIX_M2;
      m = m ^ (m >> 33);
      return m;
   endfunction

   function automatic logic [3:0][31:0] hash_words(input logic [63:0] key,
                                                   input logic [31:0] seed);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] k;
      a = {32'd0, seed};
      b = a;
      k = key * MM_C1;
      k = {k[32:0], k[63:33]};
      k = k * MM_C2;
      a = a ^ k;
      a = a ^ MM_LEN;
      b = b ^ MM_LEN;
      a = a + b;
      b = b + a;
      a = mix_down(a);
      b = mix_down(b);
      a = a + b;
      b = b + a;
      return {b[63:32], b[31:0], a[63:32], a[31:0]};
   endfunction

   // updates the shadow state on an insert and returns the status the block must answer
   function automatic status_type filter_status(input logic op, input logic [63:0] key);
      logic [3:0][31:0] words;
      int unsigned      pos;
      status_type       answer;
      words = hash_words(key, seed_q);
      if (op == OP_INSERT) begin
         for (int i = 0; i < 4; i++) begin
            pos = words[i] % FILTER_BITS;
            filter_set[pos] = 1'b1;
         end
         if (key < lowest_key_q) lowest_key_q = key;
         if (key > highest_key_q) highest_key_q = key;
         holds_keys_q = 1'b1;
         answer = STATUS_INSERT_DONE;
      end else if (!holds_keys_q || key < lowest_key_q || key > highest_key_q) begin
         answer = STATUS_OUT_RANGE;
      end else begin
         answer = STATUS_MAYBE;
         for (int i = 0; i < 4; i++) begin
            pos = words[i] % FILTER_BITS;
            if (!filter_set[pos]) answer = STATUS_MISS;
         end
      end
      return answer;
   endfunction

   function automatic logic [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(input logic op, input logic [63:0] key);
      int unsigned gap;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_INSERT) inserted_keys.push_back(key);
      expected_status.push_back(filter_status(op, key));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_AW-1:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr[CSR_AW-1:2] == CSR_IDX_HASH_SEED) begin
         seed_q = value;
         seeds_used++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_seed_readback();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_HASH_SEED;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== seed_q) begin
         $error("hash_seed readback: expected %h, actual %h", seed_q, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_empty_filter();
      check_seed_readback();
      send_request(OP_QUERY, 64'd0);
      send_request(OP_QUERY, '1);
      send_request(OP_QUERY, KEY_MID);
   endtask

   task automatic test_insert_and_range();
      send_request(OP_INSERT, KEY_MID);
      send_request(OP_INSERT, KEY_MID + 64'h1000);
      send_request(OP_QUERY, KEY_MID);
      send_request(OP_QUERY, KEY_MID + 64'h1000);
      send_request(OP_QUERY, KEY_MID - 64'd1);
      send_request(OP_QUERY, KEY_MID + 64'h1001);
      send_request(OP_QUERY, 64'd0);
      send_request(OP_QUERY, '1);
      send_request(OP_QUERY, KEY_MID + 64'h800);
      // repeated insert of the same key
      send_request(OP_INSERT, KEY_MID);
      send_request(OP_QUERY, KEY_MID);
      wait_for_results();
   endtask

   task automatic test_seed_change();
      write_register(ADDR_HASH_SEED, 32'd0);
      check_seed_readback();
      send_request(OP_QUERY, KEY_MID);
      send_request(OP_QUERY, KEY_MID + 64'h1000);
      send_request(OP_INSERT, KEY_MID + 64'h10);
      send_request(OP_QUERY, KEY_MID + 64'h10);
      wait_for_results();
      write_register(ADDR_HASH_SEED, 32'hffff_ffff);
      send_request(OP_QUERY, KEY_MID + 64'h10);
      wait_for_results();
      // unmapped register must not disturb the seed
      write_register(ADDR_UNMAPPED, $urandom);
      check_seed_readback();
      write_register(ADDR_HASH_SEED, HASH_SEED_RESET);
      send_request(OP_QUERY, KEY_MID);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      hold_pending = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 2 == 0) send_request(OP_INSERT, KEY_MID + 64'($urandom_range(0, 255)));
         else send_request(OP_QUERY, KEY_MID + 64'($urandom_range(0, 255)));
      end
      wait_for_results();
   endtask

   task automatic run_random_phase(input int unsigned count, input int unsigned span_bits);
      int unsigned r;
      logic [63:0] offset;
      logic [63:0] key;
      for (int unsigned n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         offset = random_key() >> (64 - span_bits);
         if (r < 35) begin
            key = $urandom_range(0, 1) ? KEY_MID + offset : KEY_MID - offset;
            send_request(OP_INSERT, key);
         end else if (r < 65 && inserted_keys.size() != 0) begin
            send_request(OP_QUERY, inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
         end else if (r < 80 && holds_keys_q && highest_key_q > lowest_key_q) begin
            key = lowest_key_q + random_key() % (highest_key_q - lowest_key_q);
            send_request(OP_QUERY, key);
         end else if (r < 90 && lowest_key_q != 64'd0) begin
            send_request(OP_QUERY, random_key() % lowest_key_q);
         end else if (r < 95 && highest_key_q != '1) begin
            key = highest_key_q + 64'd1 + random_key() % (~highest_key_q);
            send_request(OP_QUERY, key);
         end else begin
            send_request(OP_QUERY, random_key());
         end
      end
   endtask

   task automatic test_random_traffic();
      int unsigned spans [5] = '{8, 16, 32, 48, 62};
      for (int p = 0; p < 5; p++) begin
         wait_for_results();
         case (p)
            1: write_register(ADDR_HASH_SEED, $urandom);
            2: write_register(ADDR_HASH_SEED, 32'd0);
            3: write_register(ADDR_HASH_SEED, 32'hffff_ffff);
            4: write_register(ADDR_HASH_SEED, $urandom);
            default: ;
         endcase
         idle_enable = ($urandom_range(0, 3) != 0);
         run_random_phase(RANDOM_ITEMS / 5, spans[p]);
      end
      wait_for_results();
   endtask

   task automatic test_quiet_tail();
      idle_enable = 1'b0;
      write_register(ADDR_HASH_SEED, HASH_SEED_RESET);
      run_random_phase(30, 62);
      send_request(OP_INSERT, 64'd0);
      send_request(OP_INSERT, '1);
      send_request(OP_QUERY, 64'd0);
      send_request(OP_QUERY, '1);
      send_request(OP_QUERY, random_key());
      wait_for_results();
   endtask

   // result side: random stalls while idle_enable is set, plus one long hold when asked
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!idle_enable) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_response
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            $error("status: expected none, actual %0d", rsp_tdata[1:0]);
            error_count++;
         end else begin
            want = expected_status.pop_front();
            status_count[want]++;
            if (rsp_tdata[1:0] !== want) begin
               $error("status: expected %0d, actual %0d", want, rsp_tdata[1:0]);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned stalled_cycles;
      stalled_cycles = 0;
      while (stalled_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stalled_cycles = 0;
         else stalled_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_empty_filter();
      test_insert_and_range();
      test_seed_change();
      test_backpressure();
      test_random_traffic();
      test_quiet_tail();
      repeat (100) @(posedge clock);
      $display("summary: %0d inserts, %0d maybe present, %0d out of range or empty, %0d misses",
               status_count[STATUS_INSERT_DONE], status_count[STATUS_MAYBE],
               status_count[STATUS_OUT_RANGE], status_count[STATUS_MISS]);
      $display("summary: %0d seed writes, one long result hold, %0d errors",
               seeds_used, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/bfkr_pkg.sv
sv/bfkr_ram.sv
sv/bfkr_hash.sv
sv/bfkr_mod.sv
sv/bloom_filter_key_range_check.sv
verif/bloom_filter_key_range_check_tb.sv
